// File: src/svg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere vertex generator package
// Shared widths, constants, configuration register indices and the arctangent
// table of the rotation pipeline.
// ----------------------------------------------------------------------------
package svg_pkg;

   localparam int CountWidth   = 11;
   localparam int RadiusWidth  = 16;
   localparam int PosWidth     = 17;
   localparam int TexWidth     = 17;
   localparam int NormWidth    = 16;
   localparam int QuoWidth     = 17;
   localparam int NumWidth     = 28;
   localparam int AngleWidth   = 16;
   localparam int CordicWidth  = 34;
   localparam int UnitWidth    = 32;
   localparam int CsrIdxWidth  = 2;

   localparam int MaxDivisionsDefault    = 1024;
   localparam int AngleIterationsDefault = 16;

   localparam logic signed [31:0] TwoPiQ28   = 32'sd1686629713;
   localparam logic signed [CordicWidth-1:0] GainInvQ30 = 34'sd652032874;

   localparam logic [RadiusWidth-1:0] RadiusReset = 16'd256;
   localparam logic [CountWidth-1:0]  StackReset  = 11'd16;
   localparam logic [CountWidth-1:0]  SliceReset  = 11'd32;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_RADIUS = 2'd0,
      CSR_STACKS = 2'd1,
      CSR_SLICES = 2'd2
   } csr_index_type;

   function automatic logic signed [CordicWidth-1:0] atan_q30(input int i);
      logic [31:0] v;
      case (i)
         0:  v = 32'h3243F6A8;
         1:  v = 32'h1DAC6705;
         2:  v = 32'h0FADBAFC;
         3:  v = 32'h07F56EA6;
         4:  v = 32'h03FEAB76;
         5:  v = 32'h01FFD55B;
         6:  v = 32'h00FFFAAA;
         7:  v = 32'h007FFF55;
         8:  v = 32'h003FFFEA;
         9:  v = 32'h001FFFFD;
         10: v = 32'h000FFFFF;
         11: v = 32'h0007FFFF;
         12: v = 32'h0003FFFF;
         13: v = 32'h0001FFFF;
         14: v = 32'h0000FFFF;
         15: v = 32'h00007FFF;
         16: v = 32'h00003FFF;
         17: v = 32'h00001FFF;
         18: v = 32'h00000FFF;
         19: v = 32'h000007FF;
         20: v = 32'h000003FF;
         21: v = 32'h000001FF;
         22: v = 32'h000000FF;
         23: v = 32'h0000007F;
         default: v = 32'h0;
      endcase
      return signed'({2'b00, v});
   endfunction

endpackage
`default_nettype wire

// File: src/sphere_vertex_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted beat passes through index saturation, the one-bit-per-stage
// dividers, the rotation stages and the product stages to its result.
// Throughput: one beat per cycle; a stalled result holds the whole pipeline.
// Reset clears all valid bits and loads the register defaults (radius 256,
// 16 stacks, 32 slices).
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Turns a stack and slice grid index into position, texture coordinates and
// unit normal through dividers, two sine/cosine pipelines and product stages.
// ----------------------------------------------------------------------------
module sphere_vertex_generator #(
   parameter int MAX_DIVISIONS    = svg_pkg::MaxDivisionsDefault,
   parameter int ANGLE_ITERATIONS = svg_pkg::AngleIterationsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // stack_index [10:0], slice_index [21:11]
   input  wire logic [23:0]  req_tdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z
   output logic [135:0]      rsp_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [svg_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [15:0]  csr_data
);

   localparam int CW   = svg_pkg::CountWidth;
   localparam int QB   = svg_pkg::QuoWidth;
   localparam int NW   = svg_pkg::NumWidth;
   localparam int UW   = svg_pkg::UnitWidth;
   localparam int CLAT = ANGLE_ITERATIONS + 3;
   localparam int LAT  = 1 + QB + CLAT + 3;
   localparam int TEXD = CLAT + 2;

   logic en;
   logic [svg_pkg::RadiusWidth-1:0] radius_ff;
   logic [CW-1:0] stacks_reg_ff, slices_reg_ff, stacks, slices;
   logic [LAT-1:0] valid_ff;

   assign csr_ready  = 1'b1;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= svg_pkg::RadiusReset;
         stacks_reg_ff <= svg_pkg::StackReset;
         slices_reg_ff <= svg_pkg::SliceReset;
      end else if (csr_valid) begin
         case (csr_index)
            svg_pkg::CSR_RADIUS: radius_ff     <= csr_data;
            svg_pkg::CSR_STACKS: stacks_reg_ff <= csr_data[CW-1:0];
            svg_pkg::CSR_SLICES: slices_reg_ff <= csr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (stacks_reg_ff == '0) stacks = CW'(1);
      else if (32'(stacks_reg_ff) > 32'(MAX_DIVISIONS)) stacks = CW'(MAX_DIVISIONS);
      else stacks = stacks_reg_ff;
      if (slices_reg_ff == '0) slices = CW'(1);
      else if (32'(slices_reg_ff) > 32'(MAX_DIVISIONS)) slices = CW'(MAX_DIVISIONS);
      else slices = slices_reg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (en) valid_ff <= {valid_ff[LAT-2:0], req_tvalid};
   end

   // Index saturation stage.
   logic [CW-1:0] st_in, sl_in, st_ff, sl_ff;
   assign st_in = (req_tdata[10:0] > stacks) ? stacks : req_tdata[10:0];
   assign sl_in = (req_tdata[21:11] > slices) ? slices : req_tdata[21:11];

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
         sl_ff <= sl_in;
      end
   end

   logic [NW-1:0] num_u, num_v, num_lat;
   logic [QB-1:0] qu, qv, qlat;
   assign num_u   = NW'({sl_ff, 16'b0}) + NW'(slices >> 1);
   assign num_v   = NW'({st_ff, 16'b0}) + NW'(stacks >> 1);
   assign num_lat = NW'({st_ff, 15'b0}) + NW'(stacks >> 1);

   svg_div #(.QBITS(QB), .NBITS(NW), .DBITS(CW)) u_div_u (
      .clock(clock), .en(en), .num(num_u), .den(slices), .quo(qu));
   svg_div #(.QBITS(QB), .NBITS(NW), .DBITS(CW)) u_div_v (
      .clock(clock), .en(en), .num(num_v), .den(stacks), .quo(qv));
   svg_div #(.QBITS(QB), .NBITS(NW), .DBITS(CW)) u_div_lat (
      .clock(clock), .en(en), .num(num_lat), .den(stacks), .quo(qlat));

   logic signed [UW-1:0] ca, sa, ct, stn;

   svg_cordic #(.ITER(ANGLE_ITERATIONS)) u_cordic_lat (
      .clock(clock), .en(en), .angle(qlat[15:0]), .cos_out(ca), .sin_out(sa));
   svg_cordic #(.ITER(ANGLE_ITERATIONS)) u_cordic_lon (
      .clock(clock), .en(en), .angle(qu[15:0]), .cos_out(ct), .sin_out(stn));

   logic [2*svg_pkg::TexWidth-1:0] tex_ff [TEXD];
   always_ff @(posedge clock) begin
      if (en) begin
         tex_ff[0] <= {17'(65536) - qv, 17'(65536) - qu};
         for (int j = 1; j < TEXD; j++) tex_ff[j] <= tex_ff[j-1];
      end
   end

   // Unit direction products.
   logic signed [2*UW-1:0] uxp_ff, uzp_ff;
   logic signed [UW-1:0]   uy1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         uxp_ff <= sa * ct;
         uzp_ff <= sa * stn;
         uy1_ff <= ca;
      end
   end

   // Rounding to Q30 and radius scaling.
   logic signed [UW-1:0] ux_in, uz_in, ux_ff, uy_ff, uz_ff;
   logic signed [UW+16:0] rad_s, px_ff, py_ff, pz_ff;
   assign ux_in = UW'((uxp_ff + (64'sd1 <<< 29)) >>> 30);
   assign uz_in = UW'((uzp_ff + (64'sd1 <<< 29)) >>> 30);
   assign rad_s = (UW+17)'(signed'({1'b0, radius_ff}));

   always_ff @(posedge clock) begin
      if (en) begin
         ux_ff <= ux_in;
         uy_ff <= uy1_ff;
         uz_ff <= uz_in;
         px_ff <= rad_s * (UW+17)'(ux_in);
         py_ff <= rad_s * (UW+17)'(uy1_ff);
         pz_ff <= rad_s * (UW+17)'(uz_in);
      end
   end

   function automatic logic [16:0] pos_sat(input logic signed [UW+16:0] p);
      logic signed [UW+16:0] r;
      r = (p + (49'sd1 <<< 29)) >>> 30;
      if (r > 49'sd65535) return 17'(65535);
      if (r < -49'sd65535) return 17'(-65535);
      return r[16:0];
   endfunction

   function automatic logic [15:0] norm_sat(input logic signed [UW-1:0] u);
      logic signed [UW:0] r;
      r = ((UW+1)'(u) + 33'sd32768) >>> 16;
      if (r > 33'sd16384) return 16'(16384);
      if (r < -33'sd16384) return 16'(-16384);
      return r[15:0];
   endfunction

   logic [135:0] out_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= {3'b000, norm_sat(uz_ff), norm_sat(uy_ff), norm_sat(ux_ff),
                    tex_ff[TEXD-1], pos_sat(pz_ff), pos_sat(py_ff), pos_sat(px_ff)};
      end
   end

   assign rsp_tdata  = out_ff;
   assign rsp_tvalid = valid_ff[LAT-1];

endmodule
`default_nettype wire

// File: src/svg_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, most significant bit first.
// ----------------------------------------------------------------------------
module svg_div #(
   parameter int QBITS = svg_pkg::QuoWidth,
   parameter int NBITS = svg_pkg::NumWidth,
   parameter int DBITS = svg_pkg::CountWidth
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [NBITS-1:0] num,
   input  wire logic [DBITS-1:0] den,
   output logic      [QBITS-1:0] quo
);

   logic [NBITS-1:0] rem_in [QBITS];
   logic [NBITS-1:0] rem_ff [QBITS];
   logic [QBITS-1:0] quo_in [QBITS];
   logic [QBITS-1:0] quo_ff [QBITS];

   for (genvar k = 0; k < QBITS; k++) begin : g_stage
      logic [NBITS-1:0] rem_prev;
      logic [QBITS-1:0] quo_prev;
      logic [NBITS+QBITS:0] trial;

      if (k == 0) begin : g_first
         assign rem_prev = num;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign trial = (NBITS+QBITS+1)'(den) << (QBITS-1-k);

      always_comb begin
         if ((NBITS+QBITS+1)'(rem_prev) >= trial) begin
            rem_in[k] = rem_prev - trial[NBITS-1:0];
            quo_in[k] = quo_prev | (QBITS'(1) << (QBITS-1-k));
         end else begin
            rem_in[k] = rem_prev;
            quo_in[k] = quo_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quo = quo_ff[QBITS-1];

endmodule
`default_nettype wire

// File: src/svg_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined sine and cosine
// Quarter-turn fold, conversion to radians, one rotation step per stage and
// quadrant restore.
// ----------------------------------------------------------------------------
module svg_cordic #(
   parameter int ITER = svg_pkg::AngleIterationsDefault
) (
   input  wire logic                                    clock,
   input  wire logic                                    en,
   input  wire logic        [svg_pkg::AngleWidth-1:0]   angle,
   output logic signed      [svg_pkg::UnitWidth-1:0]    cos_out,
   output logic signed      [svg_pkg::UnitWidth-1:0]    sin_out
);

   localparam int W = svg_pkg::CordicWidth;

   logic [15:0]        folded;
   logic [1:0]         quad_in;
   logic signed [15:0] resid;
   logic signed [47:0] prod_in;
   logic signed [47:0] prod_ff;
   logic [1:0]         quad0_ff;
   logic signed [47:0] zconv;

   logic signed [W-1:0] x_ff [ITER+1];
   logic signed [W-1:0] y_ff [ITER+1];
   logic signed [W-1:0] z_ff [ITER+1];
   logic [1:0]          qd_ff [ITER+1];
   logic signed [W-1:0] x_in [ITER+1];
   logic signed [W-1:0] y_in [ITER+1];
   logic signed [W-1:0] z_in [ITER+1];

   logic signed [svg_pkg::UnitWidth-1:0] cos_in, sin_in, cos_ff, sin_ff;

   assign folded  = angle + 16'h2000;
   assign quad_in = folded[15:14];
   assign resid   = signed'(angle - {quad_in, 14'b0});
   assign prod_in = 48'(resid) * 48'(svg_pkg::TwoPiQ28);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         quad0_ff <= quad_in;
      end
   end

   assign zconv = (prod_ff + (prod_ff < 0 ? 48'sd16383 : 48'sd0)) >>> 14;
   assign x_in[0] = svg_pkg::GainInvQ30;
   assign y_in[0] = '0;
   assign z_in[0] = W'(zconv);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]  <= x_in[0];
         y_ff[0]  <= y_in[0];
         z_ff[0]  <= z_in[0];
         qd_ff[0] <= quad0_ff;
      end
   end

   for (genvar i = 0; i < ITER; i++) begin : g_rot
      logic signed [W-1:0] dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      always_comb begin
         if (z_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] - dx;
            y_in[i+1] = y_ff[i] + dy;
            z_in[i+1] = z_ff[i] - svg_pkg::atan_q30(i);
         end else begin
            x_in[i+1] = x_ff[i] + dx;
            y_in[i+1] = y_ff[i] - dy;
            z_in[i+1] = z_ff[i] + svg_pkg::atan_q30(i);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]  <= x_in[i+1];
            y_ff[i+1]  <= y_in[i+1];
            z_ff[i+1]  <= z_in[i+1];
            qd_ff[i+1] <= qd_ff[i];
         end
      end
   end

   always_comb begin
      case (qd_ff[ITER])
         2'd0: begin
            cos_in = svg_pkg::UnitWidth'(x_ff[ITER]);
            sin_in = svg_pkg::UnitWidth'(y_ff[ITER]);
         end
         2'd1: begin
            cos_in = svg_pkg::UnitWidth'(-y_ff[ITER]);
            sin_in = svg_pkg::UnitWidth'(x_ff[ITER]);
         end
         2'd2: begin
            cos_in = svg_pkg::UnitWidth'(-x_ff[ITER]);
            sin_in = svg_pkg::UnitWidth'(-y_ff[ITER]);
         end
         default: begin
            cos_in = svg_pkg::UnitWidth'(y_ff[ITER]);
            sin_in = svg_pkg::UnitWidth'(-x_ff[ITER]);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule
`default_nettype wire

// File: src/svg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere vertex generator port checker
// Watches the top-level ports for reset, stall and range behaviour.
// ----------------------------------------------------------------------------
module svg_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic [135:0] rsp_tdata,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while the pipeline is stalled");

   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[67:51] <= 17'd65536 && rsp_tdata[84:68] <= 17'd65536)
      else $error("texture coordinate out of range");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[116:101]) <= 16'sd16384
                  && $signed(rsp_tdata[116:101]) >= -16'sd16384)
      else $error("normal y out of range");

endmodule

bind sphere_vertex_generator svg_checker u_svg_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready));
`default_nettype wire

// File: tb/sv/tb_sphere_vertex_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere vertex generator testbench
// Drives grid points through the vertex generator under several radius and
// count settings, with random gaps on both streams, and compares every vertex
// against a bit-exact fixed-point predictor held in the bench.
// ----------------------------------------------------------------------------
module tb_sphere_vertex_generator;

   localparam int MaxDiv = 1024;
   localparam int Iters  = 16;
   localparam int Latency = Iters + 24;

   typedef struct packed {
      logic [15:0] norm_z, norm_y, norm_x;
      logic [16:0] tex_v, tex_u, pos_z, pos_y, pos_x;
   } vertex_type;

   logic clock = 0;
   logic reset = 1;
   logic [23:0] req_tdata = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [135:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic csr_valid = 0;
   logic csr_ready;
   svg_pkg::csr_index_type csr_index = svg_pkg::CSR_RADIUS;
   logic [15:0] csr_data = '0;

   vertex_type expected_vertices[$];
   int errors = 0;
   bit drain_stalls = 1;
   int ready_wait;
   longint radius_reg;
   longint stacks_reg;
   longint slices_reg;

   sphere_vertex_generator dut (.*);

   always #5 clock = ~clock;

   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint rshift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint effective_count(longint r);
      if (r == 0) return 1;
      if (r > MaxDiv) return MaxDiv;
      return r;
   endfunction

   task automatic rotate_angle(input longint ang, output longint c, output longint s);
      longint q, d, r, z, x, y, dx, dy, a;
      q = ((ang + 'h2000) >> 14) & 3;
      d = (ang - q * 'h4000) & 'hFFFF;
      r = d - ((d >= 'h8000) ? 'h10000 : 0);
      z = (r * longint'(svg_pkg::TwoPiQ28)) / 16384;
      x = longint'(svg_pkg::GainInvQ30);
      y = 0;
      for (int i = 0; i < Iters && i < 24; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         a = longint'(svg_pkg::atan_q30(i));
         if (z >= 0) begin
            x -= dx; y += dy; z -= a;
         end else begin
            x += dx; y -= dy; z += a;
         end
      end
      case (q)
         0: begin c = x; s = y; end
         1: begin c = -y; s = x; end
         2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   task automatic predict_vertex(input int st_in, input int sl_in, output vertex_type v);
      longint stacks, slices, st, sl, qu, qv, lat, ca, sa, ct, stn, ux, uy, uz;
      stacks = effective_count(stacks_reg);
      slices = effective_count(slices_reg);
      st = (st_in > stacks) ? stacks : st_in;
      sl = (sl_in > slices) ? slices : sl_in;
      qu = (sl * 65536 + slices / 2) / slices;
      qv = (st * 65536 + stacks / 2) / stacks;
      lat = (st * 32768 + stacks / 2) / stacks;
      rotate_angle(lat & 'hFFFF, ca, sa);
      rotate_angle(qu & 'hFFFF, ct, stn);
      ux = rshift(sa * ct, 30);
      uy = ca;
      uz = rshift(sa * stn, 30);
      v.pos_x = 17'(clamp(rshift(radius_reg * ux, 30), 65535));
      v.pos_y = 17'(clamp(rshift(radius_reg * uy, 30), 65535));
      v.pos_z = 17'(clamp(rshift(radius_reg * uz, 30), 65535));
      v.tex_u = 17'(65536 - qu);
      v.tex_v = 17'(65536 - qv);
      v.norm_x = 16'(clamp(rshift(ux, 16), 16384));
      v.norm_y = 16'(clamp(rshift(uy, 16), 16384));
      v.norm_z = 16'(clamp(rshift(uz, 16), 16384));
   endtask

   // The request stays valid after a beat so that a gapless next beat follows;
   // any other caller drops it in the same step.
   task automatic send_grid_point(input int st, input int sl);
      vertex_type v;
      int gap;
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(18);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      predict_vertex(st, sl, v);
      expected_vertices.insert(expected_vertices.size(), v);
      req_tdata <= {2'b00, 11'(sl), 11'(st)};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_register(input svg_pkg::csr_index_type idx, input int value);
      req_tvalid <= 0;
      while (expected_vertices.size() != 0) @(negedge clock);
      repeat (Latency + 4) @(negedge clock);
      csr_index <= idx;
      csr_data <= 16'(value);
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
      case (idx)
         svg_pkg::CSR_RADIUS: radius_reg = value & 'hFFFF;
         svg_pkg::CSR_STACKS: stacks_reg = value & 'h7FF;
         default: slices_reg = value & 'h7FF;
      endcase
   endtask

   task automatic set_geometry(input int rad, input int stk, input int slc);
      write_register(svg_pkg::CSR_RADIUS, rad);
      write_register(svg_pkg::CSR_STACKS, stk);
      write_register(svg_pkg::CSR_SLICES, slc);
   endtask

   // Poles, equator, index saturation and full-turn wrap at reset settings.
   task automatic test_directed_defaults;
      send_grid_point(0, 0);
      send_grid_point(16, 0);
      send_grid_point(8, 8);
      send_grid_point(2047, 2047);
      send_grid_point(17, 32);
      send_grid_point(4, 1365);
      send_grid_point(1024, 1024);
      send_grid_point(1, 31);
   endtask

   // Zero counts act as one, oversized counts clip, zero and full radius.
   task automatic test_directed_extremes;
      set_geometry(0, 0, 0);
      send_grid_point(0, 0);
      send_grid_point(1, 1);
      send_grid_point(2047, 0);
      set_geometry(65535, 2047, 2047);
      send_grid_point(0, 0);
      send_grid_point(512, 256);
      send_grid_point(1024, 1024);
      send_grid_point(1023, 1023);
      send_grid_point(2047, 1);
      set_geometry(65535, 1, 1);
      send_grid_point(0, 1);
      send_grid_point(1, 0);
      set_geometry(1, 3, 3);
      send_grid_point(1, 1);
      send_grid_point(2, 2);
   endtask

   task automatic test_random_grid;
      int stk, slc;
      for (int phase = 0; phase < 8; phase++) begin
         stk = (phase % 4 == 0) ? $urandom_range(2047) : $urandom_range(1, 64);
         slc = (phase % 3 == 0) ? $urandom_range(2047) : $urandom_range(1, 64);
         set_geometry((phase == 7) ? 65535 : $urandom_range(65535), stk, slc);
         for (int n = 0; n < 200; n++) begin
            if ($urandom_range(9) == 0)
               send_grid_point($urandom_range(2047), $urandom_range(2047));
            else
               send_grid_point($urandom_range(effective_count(stacks_reg)),
                               $urandom_range(effective_count(slices_reg)));
         end
      end
   endtask

   always begin
      @(negedge clock);
      ready_wait = (drain_stalls && $urandom_range(3) != 0) ? $urandom_range(18) : 0;
      if (ready_wait > 0) begin
         rsp_tready <= 0;
         repeat (ready_wait) @(negedge clock);
      end
      rsp_tready <= 1;
   end

   always @(posedge clock) begin
      vertex_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[132:0];
         if (expected_vertices.size() == 0) begin
            $display("%0t: unexpected vertex %h", $time, got);
            errors++;
         end else begin
            want = expected_vertices.pop_front();
            if (got !== want) begin
               $display("%0t: vertex mismatch expected %h actual %h", $time, want, got);
               errors++;
            end
         end
      end
   end

   initial begin
      radius_reg = svg_pkg::RadiusReset;
      stacks_reg = svg_pkg::StackReset;
      slices_reg = svg_pkg::SliceReset;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed_defaults();
      test_directed_extremes();
      test_random_grid();
      req_tvalid <= 0;
      while (expected_vertices.size() != 0) @(negedge clock);
      repeat (Latency + 10) @(negedge clock);
      if (errors == 0)
         $display("tb_sphere_vertex_generator OK");
      else
         $display("tb_sphere_vertex_generator NOT OK");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_sphere_vertex_generator NOT OK");
      $finish;
   end

endmodule

// File: sim.f
src/svg_pkg.sv
src/svg_div.sv
src/svg_cordic.sv
src/sphere_vertex_generator.sv
src/svg_checker.sv
tb/sv/tb_sphere_vertex_generator.sv
